### src/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

    localparam int KIND_W = 2;
    localparam int USER_W = KIND_W + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_REAL    = 2'd0,
        KIND_COMPLEX = 2'd1,
        KIND_LINEAR  = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

endpackage
`default_nettype wire

### src/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage, rounded to nearest.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt #(
    parameter int IW  = 66,
    parameter int SBW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [IW-1:0]     i_rad,
    input  wire logic [SBW-1:0]    i_side,
    output logic                   o_valid,
    output logic [IW/2-1:0]        o_root,
    output logic [SBW-1:0]         o_side
);
    localparam int RW = IW / 2;
    localparam int MW = RW + 2;

    logic            r_vld  [0:RW-1];
    logic [IW-1:0]   r_rad  [0:RW-1];
    logic [MW-1:0]   r_rem  [0:RW-1];
    logic [RW-1:0]   r_root [0:RW-1];
    logic [SBW-1:0]  r_side [0:RW-1];

    logic            r_out_vld;
    logic [RW-1:0]   r_out_root;
    logic [SBW-1:0]  r_out_side;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            p_vld;
        logic [IW-1:0]   p_rad;
        logic [MW-1:0]   p_rem;
        logic [RW-1:0]   p_root;
        logic [SBW-1:0]  p_side;
        logic [MW-1:0]   t_val;
        logic [MW-1:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        assign t_val = {p_rem[MW-3:0], p_rad[IW-1 -: 2]};
        assign trial = {p_root, 2'b01};
        assign ge    = (t_val >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= p_rad << 2;
                r_rem[k]  <= ge ? (t_val - trial) : t_val;
                r_root[k] <= {p_root[RW-2:0], ge};
                r_side[k] <= p_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_root <= (r_rem[RW-1] > MW'(r_root[RW-1])) ? (r_root[RW-1] + 1'b1)
                                                            : r_root[RW-1];
            r_out_side <= r_side[RW-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_root  = r_out_root;
    assign o_side  = r_out_side;

endmodule
`default_nettype wire

### src/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded half away from zero.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div #(
    parameter int NW  = 50,
    parameter int DW  = 33,
    parameter int SBW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NW-1:0]     i_num,
    input  wire logic [DW-1:0]     i_den,
    input  wire logic [SBW-1:0]    i_side,
    output logic                   o_valid,
    output logic [NW-1:0]          o_quot,
    output logic [SBW-1:0]         o_side
);
    logic            r_vld  [0:NW-1];
    logic [NW-1:0]   r_num  [0:NW-1];
    logic [DW-1:0]   r_rem  [0:NW-1];
    logic [DW-1:0]   r_den  [0:NW-1];
    logic [SBW-1:0]  r_side [0:NW-1];

    logic            r_out_vld;
    logic [NW-1:0]   r_out_quot;
    logic [SBW-1:0]  r_out_side;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic            p_vld;
        logic [NW-1:0]   p_num;
        logic [DW-1:0]   p_rem;
        logic [DW-1:0]   p_den;
        logic [SBW-1:0]  p_side;
        logic [DW:0]     t_val;
        logic [DW:0]     diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_num  = i_num;
            assign p_rem  = '0;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_num  = r_num[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        assign t_val = {p_rem, p_num[NW-1]};
        assign ge    = (t_val >= {1'b0, p_den});
        assign diff  = t_val - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= {p_num[NW-2:0], ge};
                r_rem[k]  <= ge ? diff[DW-1:0] : t_val[DW-1:0];
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_quot <= ({r_rem[NW-1], 1'b0} >= {1'b0, r_den[NW-1]})
                          ? (r_num[NW-1] + 1'b1) : r_num[NW-1];
            r_out_side <= r_side[NW-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_quot  = r_out_quot;
    assign o_side  = r_out_side;

endmodule
`default_nettype wire

### src/quadratic_root_solver_core.sv
// Top level of the quadratic root solver: discriminant, square root, three divider lanes.
//
// Usage:
//   Slave channel s_axis carries one coefficient set a, b, c per beat, all signed
//   fixed point with FRAC_BITS fractional bits. Master channel m_axis returns one
//   beat per input beat, in order: root_one, root_two, imag_part in tdata and the
//   root kind plus the saturation flag in tuser.
//   The pipeline holds input, product and discriminant registers, the square
//   root pipeline, a numerator setup register, the divider lanes and one output
//   register, in that order. Throughput is one beat per cycle while the
//   receiver does not stall.
//   All stages share one advance enable: the pipeline moves whenever the output
//   register is empty or being taken. When the receiver stalls with a beat held,
//   every stage holds and s_axis_tready drops; nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; s_axis_tready is high
//   in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // coef_a, coef_b, coef_c
    input  wire logic [((3*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // root_one, root_two, imag_part
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
    // root_kind, saturated
    output logic [qrs_pkg::USER_W-1:0]                   m_axis_tuser
);
    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int SIW  = 2 * W + 2;
    localparam int RW   = SIW / 2;
    localparam int NUMW = W + 2;
    localparam int NW   = NUMW + F;
    localparam int DENW = W + 1;
    localparam int TDW  = ((3 * W + 7) / 8) * 8;
    localparam int KW   = qrs_pkg::KIND_W;
    localparam int SBW  = KW + 3 + 3 * W;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input split
    logic [W-1:0] in_a, in_b, in_c;
    logic [W-1:0] n_ma, n_mb, n_mc;
    assign in_a = s_axis_tdata[W-1:0];
    assign in_b = s_axis_tdata[2*W-1:W];
    assign in_c = s_axis_tdata[3*W-1:2*W];
    assign n_ma = in_a[W-1] ? (~in_a + 1'b1) : in_a;
    assign n_mb = in_b[W-1] ? (~in_b + 1'b1) : in_b;
    assign n_mc = in_c[W-1] ? (~in_c + 1'b1) : in_c;

    logic          r_a_vld;
    logic [2:0]    r_a_s;
    logic [W-1:0]  r_a_ma, r_a_mb, r_a_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_s  <= {in_c[W-1], in_b[W-1], in_a[W-1]};
            r_a_ma <= n_ma;
            r_a_mb <= n_mb;
            r_a_mc <= n_mc;
        end
    end

    // products
    logic          r_b_vld;
    logic [2:0]    r_b_s;
    logic [W-1:0]  r_b_ma, r_b_mb, r_b_mc;
    logic [PW-1:0] r_b_bb, r_b_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_s  <= r_a_s;
            r_b_ma <= r_a_ma;
            r_b_mb <= r_a_mb;
            r_b_mc <= r_a_mc;
            r_b_bb <= r_a_mb * r_a_mb;
            r_b_ac <= r_a_ma * r_a_mc;
        end
    end

    // discriminant
    logic [SIW-1:0]    bbx, ac4, n_d;
    logic              opp, bb_ge;
    qrs_pkg::t_kind    n_kind;

    assign bbx   = {2'b00, r_b_bb};
    assign ac4   = {r_b_ac, 2'b00};
    assign opp   = (r_b_s[0] ^ r_b_s[2]) && (r_b_mc != '0);
    assign bb_ge = (bbx >= ac4);
    assign n_d   = opp ? (bbx + ac4) : (bb_ge ? (bbx - ac4) : (ac4 - bbx));

    always_comb begin
        if (r_b_ma == '0) begin
            n_kind = (r_b_mb == '0) ? qrs_pkg::KIND_NONE : qrs_pkg::KIND_LINEAR;
        end else if (!opp && !bb_ge) begin
            n_kind = qrs_pkg::KIND_COMPLEX;
        end else begin
            n_kind = qrs_pkg::KIND_REAL;
        end
    end

    logic            r_c_vld;
    logic [SIW-1:0]  r_c_d;
    logic [SBW-1:0]  r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_d    <= n_d;
            r_c_side <= {n_kind, r_b_s, r_b_ma, r_b_mb, r_b_mc};
        end
    end

    // square root
    logic            sq_vld;
    logic [RW-1:0]   sq_root;
    logic [SBW-1:0]  sq_side;

    qrs_sqrt #(
        .IW  (SIW),
        .SBW (SBW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_rad   (r_c_d),
        .i_side  (r_c_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // numerator setup
    qrs_pkg::t_kind  sd_kind;
    logic [2:0]      sd_s;
    logic [W-1:0]    sd_ma, sd_mb, sd_mc;
    logic            nb_neg;
    logic [W+2:0]    nbv, sqx, n1, n2;
    logic [NUMW-1:0] mag1, mag2;
    logic [NUMW-1:0] n_num0, n_num1, n_num2;
    logic            n_neg0, n_neg1, n_neg2;
    logic [DENW-1:0] n_den;

    assign sd_kind = qrs_pkg::t_kind'(sq_side[SBW-1 -: KW]);
    assign sd_s    = sq_side[3*W+2 -: 3];
    assign sd_ma   = sq_side[3*W-1 -: W];
    assign sd_mb   = sq_side[2*W-1 -: W];
    assign sd_mc   = sq_side[W-1:0];

    assign nb_neg = (sd_mb != '0) && !sd_s[1];
    assign nbv    = nb_neg ? ((W+3)'(0) - (W+3)'(sd_mb)) : (W+3)'(sd_mb);
    assign sqx    = (W+3)'(sq_root);
    assign n1     = nbv + sqx;
    assign n2     = nbv - sqx;
    assign mag1   = n1[W+2] ? NUMW'((W+3)'(0) - n1) : NUMW'(n1);
    assign mag2   = n2[W+2] ? NUMW'((W+3)'(0) - n2) : NUMW'(n2);

    always_comb begin
        n_num0 = '0;
        n_num1 = '0;
        n_num2 = '0;
        n_neg0 = 1'b0;
        n_neg1 = 1'b0;
        n_neg2 = 1'b0;
        n_den  = DENW'(1);
        case (sd_kind)
            qrs_pkg::KIND_REAL: begin
                n_num0 = mag1;
                n_neg0 = n1[W+2] ^ sd_s[0];
                n_num1 = mag2;
                n_neg1 = n2[W+2] ^ sd_s[0];
                n_den  = {sd_ma, 1'b0};
            end
            qrs_pkg::KIND_COMPLEX: begin
                n_num0 = NUMW'(sd_mb);
                n_neg0 = nb_neg ^ sd_s[0];
                n_num1 = NUMW'(sd_mb);
                n_neg1 = nb_neg ^ sd_s[0];
                n_num2 = NUMW'(sq_root);
                n_neg2 = sd_s[0];
                n_den  = {sd_ma, 1'b0};
            end
            qrs_pkg::KIND_LINEAR: begin
                n_num0 = NUMW'(sd_mc);
                n_neg0 = ((sd_mc != '0) && !sd_s[2]) ^ sd_s[1];
                n_num1 = NUMW'(sd_mc);
                n_neg1 = ((sd_mc != '0) && !sd_s[2]) ^ sd_s[1];
                n_den  = DENW'(sd_mb);
            end
            default: begin
                n_den = DENW'(1);
            end
        endcase
    end

    logic             r_d_vld;
    logic [NUMW-1:0]  r_d_num0, r_d_num1, r_d_num2;
    logic             r_d_neg0, r_d_neg1, r_d_neg2;
    logic [DENW-1:0]  r_d_den;
    qrs_pkg::t_kind   r_d_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_num0 <= n_num0;
            r_d_num1 <= n_num1;
            r_d_num2 <= n_num2;
            r_d_neg0 <= n_neg0;
            r_d_neg1 <= n_neg1;
            r_d_neg2 <= n_neg2;
            r_d_den  <= n_den;
            r_d_kind <= sd_kind;
        end
    end

    // divider lanes
    logic              dv_vld0, dv_vld1, dv_vld2;
    logic [NW-1:0]     dv_q0, dv_q1, dv_q2;
    logic [KW:0]       dv_side0;
    logic              dv_neg1, dv_neg2;

    qrs_div #(.NW(NW), .DW(DENW), .SBW(KW + 1)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_vld),
        .i_num   (NW'(r_d_num0) << F),
        .i_den   (r_d_den),
        .i_side  ({r_d_kind, r_d_neg0}),
        .o_valid (dv_vld0),
        .o_quot  (dv_q0),
        .o_side  (dv_side0)
    );

    qrs_div #(.NW(NW), .DW(DENW), .SBW(1)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_vld),
        .i_num   (NW'(r_d_num1) << F),
        .i_den   (r_d_den),
        .i_side  (r_d_neg1),
        .o_valid (dv_vld1),
        .o_quot  (dv_q1),
        .o_side  (dv_neg1)
    );

    qrs_div #(.NW(NW), .DW(DENW), .SBW(1)) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_vld),
        .i_num   (NW'(r_d_num2) << F),
        .i_den   (r_d_den),
        .i_side  (r_d_neg2),
        .o_valid (dv_vld2),
        .o_quot  (dv_q2),
        .o_side  (dv_neg2)
    );

    // saturate and sign: returns {clipped, value}
    function automatic logic [W:0] clip(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] lim;
        logic [NW-1:0] mag;
        logic          over;
        lim  = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - 1'b1);
        over = (q > lim);
        mag  = over ? lim : q;
        return {over, neg ? (W'(0) - mag[W-1:0]) : mag[W-1:0]};
    endfunction

    logic [W:0] cl0, cl1, cl2;
    assign cl0 = clip(dv_q0, dv_side0[0]);
    assign cl1 = clip(dv_q1, dv_neg1);
    assign cl2 = clip(dv_q2, dv_neg2);

    logic            r_out_vld;
    logic [W-1:0]    r_r1, r_r2, r_im;
    logic [KW-1:0]   r_kind;
    logic            r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld0 & dv_vld1 & dv_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1   <= cl0[W-1:0];
            r_r2   <= cl1[W-1:0];
            r_im   <= cl2[W-1:0];
            r_kind <= dv_side0[KW:1];
            r_sat  <= cl0[W] | cl1[W] | cl2[W];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDW'({r_im, r_r2, r_r1});
    assign m_axis_tuser  = {r_sat, r_kind};

endmodule
`default_nettype wire

### src/qrs_checker.sv
// Port-level checker for the quadratic root solver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module qrs_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((3*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    input wire logic [qrs_pkg::USER_W-1:0]           m_axis_tuser
);
    localparam int W = DATA_WIDTH;

    logic [W-1:0] r1, r2, im;
    logic [1:0]   kind;
    assign r1      = m_axis_tdata[W-1:0];
    assign r2      = m_axis_tdata[2*W-1:W];
    assign im      = m_axis_tdata[3*W-1:2*W];
    assign kind    = m_axis_tuser[1:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("held output beat changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && kind != qrs_pkg::KIND_COMPLEX |-> im == '0)
        else $error("imaginary part set on real result");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (kind == qrs_pkg::KIND_COMPLEX || kind == qrs_pkg::KIND_LINEAR)
        |-> r1 == r2)
        else $error("roots differ on single-root result");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && kind == qrs_pkg::KIND_NONE
        |-> r1 == '0 && r2 == '0 && m_axis_tuser[2] == 1'b0)
        else $error("degenerate result not zero");

endmodule

bind quadratic_root_solver_core qrs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### tb/tb.sv
// Testbench for quadratic_root_solver_core: random and corner coefficient sets, in-order scoreboard.
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        logic [31:0]    root_one;
        logic [31:0]    root_two;
        logic [31:0]    imag_part;
        qrs_pkg::t_kind kind;
        logic           sat;
    } t_roots;

    localparam int WD_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // coef_a, coef_b, coef_c
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // root_one, root_two, imag_part
    logic [2:0]  m_axis_tuser;        // root_kind, saturated

    int  rx_beats = 0;
    int  idle_cycles = 0;
    bit  hold_done = 1'b0;

    quadratic_root_solver_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] divide_round(input logic signed [127:0] num_s,
                                                 input bit den_neg, input logic [127:0] den,
                                                 inout bit sat);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] lim;
        bit           neg;
        mag = (num_s < 0) ? 128'(-num_s) : 128'(num_s);
        mag = mag << 16;
        q = mag / den;
        r = mag % den;
        if ((r << 1) >= den) q = q + 1;
        neg = (num_s < 0) ^ den_neg;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? 32'(-q) : 32'(q);
    endfunction

    function automatic logic [127:0] sqrt_round(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int k = 40; k >= 0; k--) begin
            t = r | (128'd1 << k);
            if (t * t <= x) r = t;
        end
        if (x > r * r + r) r = r + 1;
        return r;
    endfunction

    function automatic t_roots solve_roots(input logic [95:0] coefs);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] disc;
        logic signed [127:0] root;
        logic [127:0]        den;
        bit                  sat;
        t_roots              res;
        a = $signed(coefs[31:0]);
        b = $signed(coefs[63:32]);
        c = $signed(coefs[95:64]);
        sat = 1'b0;
        res = '0;
        if (a == 0) begin
            if (b == 0) begin
                res.kind = qrs_pkg::KIND_NONE;
            end else begin
                den = (b < 0) ? 128'(-b) : 128'(b);
                res.root_one = divide_round(-c, b < 0, den, sat);
                res.root_two = res.root_one;
                res.kind = qrs_pkg::KIND_LINEAR;
            end
        end else begin
            disc = b * b - 4 * a * c;
            den = (a < 0) ? 128'(-2 * a) : 128'(2 * a);
            if (disc >= 0) begin
                root = sqrt_round(disc);
                res.root_one = divide_round(-b + root, a < 0, den, sat);
                res.root_two = divide_round(-b - root, a < 0, den, sat);
                res.kind = qrs_pkg::KIND_REAL;
            end else begin
                root = sqrt_round(-disc);
                res.root_one = divide_round(-b, a < 0, den, sat);
                res.root_two = res.root_one;
                res.imag_part = divide_round(root, a < 0, den, sat);
                res.kind = qrs_pkg::KIND_COMPLEX;
            end
        end
        res.sat = sat;
        return res;
    endfunction

    class t_roots_scoreboard;
        t_roots pending[$];
        int     errors = 0;
        int     checked = 0;
        int     kind_seen[4];
        int     sat_seen = 0;

        task report(string msg);
            $display("MISMATCH beat %0d: %s", checked, msg);
            errors++;
        endtask

        function void note_coefs(logic [95:0] coefs);
            pending.insert(pending.size(), solve_roots(coefs));
        endfunction

        task check_roots(logic [95:0] data, logic [2:0] user);
            t_roots exp_r;
            if (pending.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            exp_r = pending.pop_front();
            kind_seen[exp_r.kind]++;
            if (exp_r.sat) sat_seen++;
            if (data[31:0] !== exp_r.root_one)
                report($sformatf("root_one %h exp %h", data[31:0], exp_r.root_one));
            if (data[63:32] !== exp_r.root_two)
                report($sformatf("root_two %h exp %h", data[63:32], exp_r.root_two));
            if (data[95:64] !== exp_r.imag_part)
                report($sformatf("imag_part %h exp %h", data[95:64], exp_r.imag_part));
            if (user[1:0] !== exp_r.kind)
                report($sformatf("root_kind %0d exp %0d", user[1:0], exp_r.kind));
            if (user[2] !== exp_r.sat)
                report($sformatf("saturated %0d exp %0d", user[2], exp_r.sat));
            checked++;
        endtask
    endclass

    t_roots_scoreboard sb = new();

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_coefs(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_roots(m_axis_tdata, m_axis_tuser);
            rx_beats++;
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WD_LIMIT);
            $display("quadratic_root_solver_core test failed");
            $finish;
        end
    end

    int max_gap = 11;

    task automatic send_coefs(input logic [95:0] coefs);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= coefs;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = $urandom_range(max_gap, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3, 4:    return $urandom();
            5:       return 32'($signed($urandom_range(32'h20000, 0)) - 32'sh10000);
            6:       return 32'($signed($urandom_range(32'h800, 0)) - 32'sh400);
            default: return 32'($signed($urandom_range(32'h2000000, 0)) - 32'sh1000000);
        endcase
    endfunction

    initial begin
        logic [31:0] xs[] = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff};
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // two real, complex, negative a complex, linear, none, double root
        send_coefs({32'hfffe_0000, 32'hfffd_0000, 32'h0001_0000});
        send_coefs({32'h0001_0000, 32'h0000_0000, 32'h0001_0000});
        send_coefs({32'hffff_0000, 32'h0000_0000, 32'hffff_0000});
        send_coefs({32'h0002_0000, 32'h0003_0000, 32'h0000_0000});
        send_coefs({32'h0005_0000, 32'h0000_0000, 32'h0000_0000});
        send_coefs({32'h0001_0000, 32'hfffe_0000, 32'h0001_0000});
        for (int i = 0; i < 19; i++)
            send_coefs({xs[$urandom_range(4, 0)], xs[$urandom_range(4, 0)], xs[i % 5]});
        for (int i = 0; i < 1200; i++) begin
            if (i % 150 == 0) max_gap = ($urandom_range(2, 0) == 0) ? 0 : 11;
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
            send_coefs({c, b, a});
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        $display("checked %0d result beats: real %0d, complex %0d, linear %0d, none %0d",
                 sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
                 sb.kind_seen[3]);
        $display("saturated results %0d, one long output stall included", sb.sat_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("quadratic_root_solver_core test passed");
        else
            $display("quadratic_root_solver_core test failed");
        $finish;
    end

    initial begin
        int wait_cycles;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!hold_done && rx_beats >= 400) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end
            wait_cycles = (max_gap == 0) ? 0 : $urandom_range(11, 0);
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end
endmodule

### files.f
src/qrs_pkg.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/quadratic_root_solver_core.sv
src/qrs_checker.sv
tb/tb.sv
